/* rtl/cco_pkg.sv */
// ----------------------------------------------------------------------------
// cco_pkg: shared types and constants of the cosine cutoff weight block
// register indexes, field widths, pipeline item types and the raised
// cosine evaluation used to build the cosine table at elaboration
// ----------------------------------------------------------------------------
package cco_pkg;

  localparam int COS_TABLE_BITS_DEF = 10;
  localparam int COORD_W = 16;
  localparam int DIST_W  = 18;
  localparam int RAD_W   = 18;
  localparam int INVW_W  = 22;
  localparam int WGT_W   = 16;
  localparam int CFG_W   = 22;
  localparam int IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CUTOFF  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PLATEAU = 2'd1;
  localparam logic [IDX_W-1:0] REG_INVW    = 2'd2;

  localparam logic [WGT_W-1:0] WEIGHT_ONE = 16'h8000;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  // distance leaving the square root pipeline
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
  } dist_item_t;

  // finished result
  typedef struct packed {
    logic              valid;
    logic [WGT_W-1:0]  weight;
    logic              in_cutoff;
    logic [DIST_W-1:0] distance;
  } result_item_t;

  // 0.5*(1+cos(pi*k/2^bits)) in Q1.15, Horner form of the Taylor series
  function automatic logic [WGT_W-1:0] raised_cos(longint unsigned k_in, int bits);
    longint unsigned full;
    longint unsigned k;
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned r;
    longint          last;
    logic            neg;
    longint unsigned w;
    full = 64'd1 << bits;
    k    = k_in;
    neg  = 1'b0;
    if (k > (full >> 1)) begin
      k   = full - k;
      neg = 1'b1;
    end
    theta = (PI_Q30 * k) >> bits;
    x2    = (theta * theta) >> 30;
    r     = ONE_Q30;
    // terms of degree 14 down to 4, divisors (2n-1)*2n
    r = ONE_Q30 - (((x2 * r) >> 30) / 64'd182);
    r = ONE_Q30 - (((x2 * r) >> 30) / 64'd132);
    r = ONE_Q30 - (((x2 * r) >> 30) / 64'd90);
    r = ONE_Q30 - (((x2 * r) >> 30) / 64'd56);
    r = ONE_Q30 - (((x2 * r) >> 30) / 64'd30);
    r = ONE_Q30 - (((x2 * r) >> 30) / 64'd12);
    last = longint'(ONE_Q30) - longint'(((x2 * r) >> 30) >> 1);
    if (last < 0) last = 0;
    r = longint'(last);
    if (neg) w = (ONE_Q30 - r + 64'd32768) >> 16;
    else     w = (ONE_Q30 + r + 64'd32768) >> 16;
    return w[WGT_W-1:0];
  endfunction

endpackage

/* rtl/cco_sample_if.sv */
// ----------------------------------------------------------------------------
// cco_sample_if: input channel
// valid/ready handshake carrying a position and an expansion centre
// ----------------------------------------------------------------------------
interface cco_sample_if import cco_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] position_x;
  logic signed [COORD_W-1:0] position_y;
  logic signed [COORD_W-1:0] position_z;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;

  modport source (output valid, position_x, position_y, position_z,
                  center_x, center_y, center_z, input ready);
  modport sink   (input valid, position_x, position_y, position_z,
                  center_x, center_y, center_z, output ready);
endinterface

/* rtl/cco_result_if.sv */
// ----------------------------------------------------------------------------
// cco_result_if: output channel
// valid/ready handshake carrying weight, cutoff flag and distance
// ----------------------------------------------------------------------------
interface cco_result_if import cco_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WGT_W-1:0]  weight;
  logic              inside_cutoff;
  logic [DIST_W-1:0] center_distance;

  modport source (output valid, weight, inside_cutoff, center_distance, input ready);
  modport sink   (input valid, weight, inside_cutoff, center_distance, output ready);
endinterface

/* rtl/cco_dist.sv */
// ----------------------------------------------------------------------------
// cco_dist: distance pipeline
// differences and squares, sum of squares, then one root bit per stage
// ----------------------------------------------------------------------------
module cco_dist import cco_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] position_x,
  input  logic signed [COORD_W-1:0] position_y,
  input  logic signed [COORD_W-1:0] position_z,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] center_z,
  output dist_item_t                dist_out
);

  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int RW      = SUM_W + 1;

  logic signed [COORD_W:0]   dx, dy, dz;
  logic signed [2*COORD_W+1:0] px, py, pz;
  logic [SQ_W-1:0]  sqx, sqy, sqz;
  logic             sq_valid;
  logic [SUM_W-1:0] sum;
  logic             sum_valid;

  logic [RW-1:0] rem  [0:ROOT_W];
  logic [RW-1:0] root [0:ROOT_W];
  logic          vld  [0:ROOT_W];

  // differences and squares
  assign dx = (COORD_W+1)'(position_x) - (COORD_W+1)'(center_x);
  assign dy = (COORD_W+1)'(position_y) - (COORD_W+1)'(center_y);
  assign dz = (COORD_W+1)'(position_z) - (COORD_W+1)'(center_z);
  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (en) begin
      sq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= px[SQ_W-1:0];
      sqy <= py[SQ_W-1:0];
      sqz <= pz[SQ_W-1:0];
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
    end
  end

  assign rem[0]  = RW'(sum);
  assign root[0] = '0;
  assign vld[0]  = sum_valid;

  // square root, one result bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOT_W - 1 - j));
    logic [RW-1:0] trial;
    assign trial = root[j] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[j] >= trial) begin
          rem[j+1]  <= rem[j] - trial;
          root[j+1] <= (root[j] >> 1) + BIT;
        end else begin
          rem[j+1]  <= rem[j];
          root[j+1] <= root[j] >> 1;
        end
      end
    end
  end

  assign dist_out.valid    = vld[ROOT_W];
  assign dist_out.distance = DIST_W'(root[ROOT_W][ROOT_W-1:0]);

endmodule

/* rtl/cco_weight.sv */
// ----------------------------------------------------------------------------
// cco_weight: weight pipeline
// radius compares and phase product, table index, cosine table lookup
// ----------------------------------------------------------------------------
module cco_weight import cco_pkg::*; #(
  parameter int COS_BITS = COS_TABLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  dist_item_t        dist_in,
  input  logic [RAD_W-1:0]  cutoff_radius,
  input  logic [RAD_W-1:0]  plateau_radius,
  input  logic [INVW_W-1:0] inverse_width,
  output result_item_t      result_out
);

  localparam int FULL    = 1 << COS_BITS;
  localparam int SHIFT   = 26 - COS_BITS;
  localparam int PHASE_W = RAD_W + INVW_W;
  localparam int K_W     = COS_BITS + 1;

  typedef logic [WGT_W-1:0] rom_t [0:FULL];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i <= FULL; i++) begin
      t[i] = raised_cos(longint'(i), COS_BITS);
    end
    return t;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  // stage 1: compares and phase product
  logic               v1, plat1, band1, ins1;
  logic [DIST_W-1:0]  d1;
  logic [PHASE_W-1:0] phase1;
  logic [RAD_W-1:0]   delta;

  assign delta = dist_in.distance - plateau_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= dist_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1     <= dist_in.distance;
      plat1  <= (dist_in.distance != '0) && (dist_in.distance <= plateau_radius);
      band1  <= (dist_in.distance > plateau_radius) &&
                (dist_in.distance <= cutoff_radius);
      ins1   <= dist_in.distance < cutoff_radius;
      phase1 <= PHASE_W'(delta) * PHASE_W'(inverse_width);
    end
  end

  // stage 2: table index, saturated at pi
  logic               v2, plat2, band2, ins2;
  logic [DIST_W-1:0]  d2;
  logic [K_W-1:0]     k2;
  logic [PHASE_W-1:0] kraw;

  assign kraw = phase1 >> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2    <= d1;
      plat2 <= plat1;
      band2 <= band1;
      ins2  <= ins1;
      k2    <= (kraw > PHASE_W'(FULL)) ? K_W'(FULL) : kraw[K_W-1:0];
    end
  end

  // stage 3: table lookup and weight select
  logic              v3, ins3;
  logic [DIST_W-1:0] d3;
  logic [WGT_W-1:0]  w3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3   <= d2;
      ins3 <= ins2;
      if (plat2)      w3 <= WEIGHT_ONE;
      else if (band2) w3 <= COS_ROM[k2];
      else            w3 <= '0;
    end
  end

  assign result_out.valid     = v3;
  assign result_out.weight    = w3;
  assign result_out.in_cutoff = ins3;
  assign result_out.distance  = d3;

endmodule

/* rtl/cosine_cutoff_weight.sv */
// pipeline: 2 square and sum stages, 17 square root stages and 3 weight
//   stages lie between request accepted and result shown
// throughput: one request per cycle while the skid register is empty; the
//   output skid register lets the pipeline take a request while the last result waits
// reset: synchronous, clears valid bits and skid, loads register defaults
// ----------------------------------------------------------------------------
// cosine_cutoff_weight: smooth cosine cutoff weight with inner plateau
// distance between position and centre, weight in Q1.15 and cutoff flag
// ----------------------------------------------------------------------------
module cosine_cutoff_weight import cco_pkg::*; #(
  parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  cco_sample_if.sink        sample,
  cco_result_if.source      result
);

  logic [RAD_W-1:0]  cutoff_radius;
  logic [RAD_W-1:0]  plateau_radius;
  logic [INVW_W-1:0] inverse_width;

  logic         en;
  logic         skid_full;
  result_item_t skid;
  result_item_t last;
  dist_item_t   dist_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_radius  <= RAD_W'(4096);
      plateau_radius <= RAD_W'(3072);
      inverse_width  <= INVW_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CUTOFF:  cutoff_radius  <= cfg_data[RAD_W-1:0];
        REG_PLATEAU: plateau_radius <= cfg_data[RAD_W-1:0];
        REG_INVW:    inverse_width  <= cfg_data[INVW_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the skid register is empty
  assign en           = !skid_full;
  assign sample.ready = !skid_full;

  cco_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sample.valid),
    .position_x (sample.position_x),
    .position_y (sample.position_y),
    .position_z (sample.position_z),
    .center_x   (sample.center_x),
    .center_y   (sample.center_y),
    .center_z   (sample.center_z),
    .dist_out   (dist_item)
  );

  cco_weight #(.COS_BITS(COS_TABLE_BITS)) u_weight (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .dist_in        (dist_item),
    .cutoff_radius  (cutoff_radius),
    .plateau_radius (plateau_radius),
    .inverse_width  (inverse_width),
    .result_out     (last)
  );

  // skid register holds a result the sink did not take
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (!skid_full && last.valid && !result.ready) begin
      skid_full <= 1'b1;
    end else if (skid_full && result.ready) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid <= last;
    end
  end

  // output select
  assign result.valid           = skid_full || last.valid;
  assign result.weight          = skid_full ? skid.weight    : last.weight;
  assign result.inside_cutoff   = skid_full ? skid.in_cutoff : last.in_cutoff;
  assign result.center_distance = skid_full ? skid.distance  : last.distance;

  // checks
  a_ready_after_reset: assert property (@(posedge clk) rst |=> sample.ready)
    else $error("ready low after reset");
  a_skid_shown: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> result.valid)
    else $error("held result not shown");
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.weight <= WEIGHT_ONE)
    else $error("weight above one");
  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.center_distance == '0) |-> result.weight == '0)
    else $error("non-zero weight at zero distance");

endmodule

/* dv/cco_tb_if.sv */
// ----------------------------------------------------------------------------
// cco_tb_pkg: testbench package for the two handshake channels
// the channel interfaces come from the rtl folder; nothing extra is needed
// here beyond a shared record type for one expected result
// ----------------------------------------------------------------------------
package cco_tb_pkg;
  import cco_pkg::*;

  // one expected result
  typedef struct packed {
    logic [WGT_W-1:0]  weight;
    logic              inside_cutoff;
    logic [DIST_W-1:0] center_distance;
  } weight_result_t;
endpackage

/* dv/cco_checker.sv */
// ----------------------------------------------------------------------------
// cco_checker: result predictor and comparison
// watches configuration writes and both channels, works out the weight,
// cutoff flag and distance of each request and compares in order
// ----------------------------------------------------------------------------
module cco_checker import cco_pkg::*; import cco_tb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  cco_sample_if.sink       sample,
  cco_result_if.sink       result,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBITS = COS_TABLE_BITS_DEF;

  logic [RAD_W-1:0]  cutoff_q;
  logic [RAD_W-1:0]  plateau_q;
  logic [INVW_W-1:0] invw_q;
  weight_result_t    expected_q[$];

  assign pending = expected_q.size();

  // floor square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned rt;
    longint unsigned b;
    rt = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= rt + b) begin
        n -= rt + b;
        rt = (rt >> 1) + b;
      end else begin
        rt >>= 1;
      end
      b >>= 2;
    end
    return rt;
  endfunction

  // raised cosine at phase step k of 2^TBITS, Horner Taylor series
  function automatic longint unsigned cos_weight(longint unsigned k);
    longint unsigned full;
    longint unsigned th;
    longint unsigned sq;
    longint unsigned acc;
    longint          tail;
    logic            flip;
    full = 64'd1 << TBITS;
    flip = 1'b0;
    if (k > (full >> 1)) begin
      k = full - k;
      flip = 1'b1;
    end
    th = (PI_Q30 * k) >> TBITS;
    sq = (th * th) >> 30;
    acc = ONE_Q30;
    for (int n = 7; n >= 2; n--)
      acc = ONE_Q30 - (((sq * acc) >> 30) / longint'((2 * n - 1) * (2 * n)));
    tail = longint'(ONE_Q30) - longint'(((sq * acc) >> 30) / 2);
    if (tail < 0) tail = 0;
    acc = tail;
    if (flip) return (ONE_Q30 - acc + 32768) >> 16;
    return (ONE_Q30 + acc + 32768) >> 16;
  endfunction

  // expected result of one request
  function automatic weight_result_t predict_weight(
      logic signed [COORD_W-1:0] px, py, pz, cx, cy, cz);
    longint          dx, dy, dz;
    longint unsigned d;
    longint unsigned k;
    longint unsigned w;
    weight_result_t  r;
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    dz = longint'(pz) - longint'(cz);
    d = root_floor(dx * dx + dy * dy + dz * dz);
    if (d > 262143) d = 262143;
    if (d != 0 && d <= plateau_q) begin
      r.weight = WEIGHT_ONE;
    end else if (d > plateau_q && d <= cutoff_q) begin
      k = ((d - plateau_q) * invw_q) >> (26 - TBITS);
      if (k > (64'd1 << TBITS)) k = 64'd1 << TBITS;
      w = cos_weight(k);
      r.weight = w[WGT_W-1:0];
    end else begin
      r.weight = '0;
    end
    r.inside_cutoff = d < cutoff_q;
    r.center_distance = d[DIST_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    weight_result_t e;
    int errs;
    errs = 0;
    if (rst) begin
      cutoff_q <= RAD_W'(4096);
      plateau_q <= RAD_W'(3072);
      invw_q <= INVW_W'(65536);
      expected_q.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_CUTOFF: cutoff_q <= cfg_data[RAD_W-1:0];
          REG_PLATEAU: plateau_q <= cfg_data[RAD_W-1:0];
          REG_INVW: invw_q <= cfg_data[INVW_W-1:0];
          default: ;
        endcase
      end
      // accepted request
      if (sample.valid && sample.ready)
        expected_q.push_back(predict_weight(sample.position_x, sample.position_y,
          sample.position_z, sample.center_x, sample.center_y, sample.center_z));
      // accepted result
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: weight %0d", result.weight);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (result.weight !== e.weight) begin
            $error("weight expected %0d actual %0d", e.weight, result.weight);
            errs++;
          end
          if (result.inside_cutoff !== e.inside_cutoff) begin
            $error("inside_cutoff expected %0d actual %0d", e.inside_cutoff,
              result.inside_cutoff);
            errs++;
          end
          if (result.center_distance !== e.center_distance) begin
            $error("center_distance expected %0d actual %0d", e.center_distance,
              result.center_distance);
            errs++;
          end
        end
      end
      if (errs != 0)
        fail_count <= fail_count + errs;
    end
  end
endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: cosine cutoff weight testbench
// directed corner requests, then random pair positions over several
// register settings, with random idling, a long result back-pressure and
// a drain pause; the checker keeps the verdict
// ----------------------------------------------------------------------------
module tb import cco_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 5000;

  logic             clk = 0;
  logic             rst = 1;
  logic             cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int               fail_count;
  int               pending;
  int               idle_cycles = 0;
  int               hold_off = 0;
  bit               long_hold = 0;
  bit               quiet = 0;
  logic [RAD_W-1:0] cut_now = 4096;
  logic [RAD_W-1:0] plat_now = 3072;

  cco_sample_if sample ();
  cco_result_if result ();

  cosine_cutoff_weight uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample(sample.sink), .result(result.source)
  );

  cco_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .sample(sample.sink), .result(result.sink),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    sample.valid = 0;
    sample.position_x = '0;
    sample.position_y = '0;
    sample.position_z = '0;
    sample.center_x = '0;
    sample.center_y = '0;
    sample.center_z = '0;
    result.ready = 0;
  end

  // result side: random stall bursts, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 0;
    end else if (long_hold) begin
      result.ready <= 0;
      hold_off <= 120;
      long_hold <= 0;
    end else if (hold_off > 0) begin
      result.ready <= 0;
      hold_off <= hold_off - 1;
    end else if (quiet || $urandom_range(3) != 0) begin
      result.ready <= 1;
    end else begin
      result.ready <= 0;
      hold_off <= $urandom_range(16);
    end
  end

  // watchdog on acceptance
  always @(posedge clk) begin
    if ((sample.valid && sample.ready) || (result.valid && result.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_CUTOFF) cut_now = val[RAD_W-1:0];
    if (idx == REG_PLATEAU) plat_now = val[RAD_W-1:0];
  endtask

  // offer one request and wait for acceptance, sometimes after a random gap
  task automatic send_pair(logic [COORD_W-1:0] px, py, pz, cx, cy, cz);
    if (!quiet && $urandom_range(5) == 0) begin
      sample.valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    sample.valid <= 1;
    sample.position_x <= px;
    sample.position_y <= py;
    sample.position_z <= pz;
    sample.center_x <= cx;
    sample.center_y <= cy;
    sample.center_z <= cz;
    do @(posedge clk); while (!sample.ready);
  endtask

  task automatic drain_all();
    sample.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // pair with distance near a target along one axis, random centre
  task automatic send_near(int target);
    int c;
    int off;
    logic [COORD_W-1:0] cc;
    logic [COORD_W-1:0] co;
    c = $urandom_range(0, 65535) - 32768;
    c = c / 4;
    off = target + $signed($urandom_range(0, 8)) - 4;
    if (off > 32767 - c) off = 32767 - c;
    if (off < -32768 - c) off = -32768 - c;
    cc = COORD_W'(c);
    co = COORD_W'(c + off);
    case ($urandom_range(2))
      0: send_pair(co, cc, cc, cc, cc, cc);
      1: send_pair(cc, co, cc, cc, cc, cc);
      default: send_pair(cc, cc, co, cc, cc, cc);
    endcase
  endtask

  task automatic random_phase(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      if (sel < 3)
        send_pair(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
          COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      else if (sel < 5)
        send_near($urandom_range(0, 32767));
      else
        send_near(plat_now + $urandom_range(0, cut_now > plat_now ?
          cut_now - plat_now + 8 : 64));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed corners at reset settings
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_pair(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pair(16'hffff, 0, 0, 0, 0, 0);
    send_pair(3072, 0, 0, 0, 0, 0);
    send_pair(3073, 0, 0, 0, 0, 0);
    send_pair(0, 3584, 0, 0, 0, 0);
    send_pair(0, 0, 4095, 0, 0, 0);
    send_pair(4096, 0, 0, 0, 0, 0);
    send_pair(4097, 0, 0, 0, 0, 0);
    send_pair(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    drain_all();

    // plateau beyond cutoff, zero inverse width
    write_reg(REG_CUTOFF, 2000);
    write_reg(REG_PLATEAU, 3000);
    write_reg(REG_INVW, 0);
    send_pair(2500, 0, 0, 0, 0, 0);
    send_pair(3500, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    drain_all();

    // zero radii, then full cutoff and extreme inverse width (phase beyond pi)
    write_reg(REG_CUTOFF, 0);
    write_reg(REG_PLATEAU, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(5, 0, 0, 0, 0, 0);
    drain_all();
    write_reg(REG_CUTOFF, 22'h3ffff);
    write_reg(REG_INVW, 22'h3fffff);
    write_reg(3, 22'h155);
    send_pair(1, 0, 0, 0, 0, 0);
    send_pair(4000, 0, 0, 0, 0, 0);
    send_pair(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    drain_all();

    // reset settings, random, with long back-pressure
    write_reg(REG_CUTOFF, 4096);
    write_reg(REG_PLATEAU, 3072);
    write_reg(REG_INVW, 65536);
    long_hold <= 1;
    random_phase(200);
    drain_all();

    // wide band, fine inverse width
    write_reg(REG_CUTOFF, 30000);
    write_reg(REG_PLATEAU, 1000);
    write_reg(REG_INVW, 2300);
    random_phase(200);
    drain_all();

    // full range settings, then zero plateau with a mid-range cutoff
    write_reg(REG_CUTOFF, 22'h3ffff);
    write_reg(REG_PLATEAU, 22'h3ffff);
    write_reg(REG_INVW, 22'h2aaaaa);
    random_phase(100);
    drain_all();
    write_reg(REG_CUTOFF, 12000);
    write_reg(REG_PLATEAU, 0);
    write_reg(REG_INVW, 6000);
    random_phase(150);
    drain_all();

    // last part: no idling
    write_reg(REG_CUTOFF, $urandom_range(0, 40000));
    write_reg(REG_PLATEAU, $urandom_range(0, 20000));
    write_reg(REG_INVW, $urandom_range(0, 22'h3fffff));
    quiet = 1;
    random_phase(175);
    drain_all();

    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* filelist.f */
rtl/cco_pkg.sv
rtl/cco_sample_if.sv
rtl/cco_result_if.sv
rtl/cco_dist.sv
rtl/cco_weight.sv
rtl/cosine_cutoff_weight.sv
dv/cco_tb_if.sv
dv/cco_checker.sv
dv/tb.sv
